[rtl/bpgt_pkg.sv]
package bpgt_pkg;

  localparam int FracBits = 16;
  localparam int PtW = 40;
  localparam int MaxGrid = 64;
  localparam int DivW = 42;
  localparam int RecipShift = 24;

  typedef enum logic [2:0] {
    CFG_STEP        = 3'd0,
    CFG_LINE_LEN    = 3'd1,
    CFG_VIEW_WIDTH  = 3'd2,
    CFG_VIEW_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        point_index;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic [5:0]        cell_row;
    logic [5:0]        cell_col;
  } in_req_t;

  typedef struct packed {
    logic signed [39:0] vert_x;
    logic signed [39:0] vert_y;
    logic               last_vertex;
  } out_vert_t;

  typedef struct packed {
    logic signed [39:0] x;
    logic signed [39:0] y;
  } pt_t;

  function automatic logic signed [39:0] sat40(input logic signed [55:0] s);
    logic fits;
    fits = (&s[55:39]) | ~(|s[55:39]);
    if (fits) begin
      return s[39:0];
    end else if (s[55]) begin
      return {1'b1, {39{1'b0}}};
    end else begin
      return {1'b0, {39{1'b1}}};
    end
  endfunction

  function automatic logic signed [39:0] lerp40(input logic signed [39:0] a,
                                               input logic signed [39:0] b,
                                               input logic [15:0] t);
    logic signed [40:0] df;
    logic signed [57:0] pr;
    logic signed [57:0] sh;
    logic signed [55:0] s;
    df = 41'(b) - 41'(a);
    pr = 58'(df) * 58'(signed'({1'b0, t}));
    sh = pr >>> FracBits;
    s = 56'(a) + sh[55:0];
    return sat40(s);
  endfunction

  function automatic pt_t lerp_pt(input pt_t a, input pt_t b, input logic [15:0] t);
    pt_t r;
    r.x = lerp40(a.x, b.x, t);
    r.y = lerp40(a.y, b.y, t);
    return r;
  endfunction

endpackage

[rtl/bezier_patch_grid_tessellator_core.sv]
// Bezier patch grid tessellator. Load requests store one scaled control point each; a
// cell request yields six vertices, one per cycle while the output is not stalled, and
// the next cell request can be taken as the last vertex of the current one issues. The
// single lattice pipeline evaluates one vertex per cycle unless the output stalls.
// After reset, after every load request and after every configuration write, a 42-step
// serial divider recomputes the row blend terms; input requests are held off while it
// runs. A load request also waits until no cell is in flight.
module bezier_patch_grid_tessellator_core import bpgt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_req_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_vert_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [16:0] cfg_data
);

  logic [16:0] step_r;
  logic [6:0]  line_len_r;
  logic [14:0] view_width_r;
  logic [14:0] view_height_r;
  pt_t         cp_r [8];

  logic [6:0] len;
  always_comb begin
    if (line_len_r == 7'd0) begin
      len = 7'd1;
    end else if (line_len_r > 7'(MaxGrid)) begin
      len = 7'(MaxGrid);
    end else begin
      len = line_len_r;
    end
  end

  // distortion vectors
  logic signed [40:0] sab_x, sab_y, scd_x, scd_y;
  logic signed [40:0] abx, aby, cdx, cdy;
  logic signed [41:0] dx, dy;
  always_comb begin
    sab_x = 41'(cp_r[0].x) + 41'(cp_r[2].x);
    sab_y = 41'(cp_r[0].y) + 41'(cp_r[2].y);
    scd_x = 41'(cp_r[6].x) + 41'(cp_r[4].x);
    scd_y = 41'(cp_r[6].y) + 41'(cp_r[4].y);
    abx = 41'(cp_r[1].x) - 41'(signed'(sab_x[40:1]));
    aby = 41'(cp_r[1].y) - 41'(signed'(sab_y[40:1]));
    cdx = 41'(cp_r[5].x) - 41'(signed'(scd_x[40:1]));
    cdy = 41'(cp_r[5].y) - 41'(signed'(scd_y[40:1]));
    dx = 42'(cdx) - 42'(abx);
    dy = 42'(cdy) - 42'(aby);
  end

  // serial divider, lanes: dx, dy, reciprocal
  logic             div_start_r, div_busy_r, div_fin_r;
  logic [5:0]       div_cnt_r;
  logic [DivW-1:0]  num_r [3];
  logic [DivW-1:0]  quo_r [3];
  logic [6:0]       rem_r [3];
  logic             neg_r [2];
  logic [DivW-1:0]  num_nxt [3];
  logic [DivW-1:0]  quo_nxt [3];
  logic [6:0]       rem_nxt [3];
  logic [7:0]       trial;

  always_comb begin
    trial = '0;
    for (int k = 0; k < 3; k++) begin
      trial = {rem_r[k], num_r[k][DivW-1]};
      num_nxt[k] = {num_r[k][DivW-2:0], 1'b0};
      if (trial >= {1'b0, len}) begin
        rem_nxt[k] = 7'(trial - {1'b0, len});
        quo_nxt[k] = {quo_r[k][DivW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[6:0];
        quo_nxt[k] = {quo_r[k][DivW-2:0], 1'b0};
      end
    end
  end

  logic signed [42:0] q0_x_r, q0_y_r;
  logic [6:0]         r0_x_r, r0_y_r;
  logic [24:0]        recip_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (neg_r[k] && rem_r[k] != 7'd0) begin
        if (k == 0) begin
          q0_x_r <= -signed'({1'b0, quo_r[k]}) - 43'sd1;
          r0_x_r <= len - rem_r[k];
        end else begin
          q0_y_r <= -signed'({1'b0, quo_r[k]}) - 43'sd1;
          r0_y_r <= len - rem_r[k];
        end
      end else if (neg_r[k]) begin
        if (k == 0) begin
          q0_x_r <= -signed'({1'b0, quo_r[k]});
          r0_x_r <= rem_r[k];
        end else begin
          q0_y_r <= -signed'({1'b0, quo_r[k]});
          r0_y_r <= rem_r[k];
        end
      end else begin
        if (k == 0) begin
          q0_x_r <= signed'({1'b0, quo_r[k]});
          r0_x_r <= rem_r[k];
        end else begin
          q0_y_r <= signed'({1'b0, quo_r[k]});
          r0_y_r <= rem_r[k];
        end
      end
    end
    recip_r <= quo_r[2][24:0] + 25'(rem_r[2] != 7'd0);
  end

  always_ff @(posedge clk) begin
    if (div_start_r) begin
      num_r[0] <= dx[41] ? 42'(-dx) : 42'(dx);
      num_r[1] <= dy[41] ? 42'(-dy) : 42'(dy);
      num_r[2] <= 42'(1) << RecipShift;
      neg_r[0] <= dx[41];
      neg_r[1] <= dy[41];
      for (int k = 0; k < 3; k++) begin
        quo_r[k] <= '0;
        rem_r[k] <= '0;
      end
    end else if (div_busy_r) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= num_nxt[k];
        quo_r[k] <= quo_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
    end
  end

  // handshake and sequencer
  logic       adv, pipe_any, in_acc, cell_acc, load_acc, issue;
  logic       busy_r;
  logic [2:0] cnt_r;
  logic [5:0] row_r, col_r;
  logic       v_r [6];

  assign adv = !(v_r[5] && out_stall);
  assign pipe_any = v_r[0] | v_r[1] | v_r[2] | v_r[3] | v_r[4] | v_r[5];
  assign in_stall = div_start_r | div_busy_r | div_fin_r | !adv |
                    (busy_r && cnt_r != 3'd5) |
                    (!in_data.req_type && (busy_r || pipe_any));
  assign in_acc = in_valid && !in_stall;
  assign cell_acc = in_acc && in_data.req_type;
  assign load_acc = in_acc && !in_data.req_type;
  assign issue = busy_r && adv;
  assign cfg_ready = 1'b1;

  logic signed [35:0] ld_x, ld_y;
  assign ld_x = 36'(in_data.point_x) * 36'(signed'({1'b0, view_width_r}));
  assign ld_y = 36'(in_data.point_y) * 36'(signed'({1'b0, view_height_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 17'd4096;
      line_len_r <= 7'd16;
      view_width_r <= 15'd1024;
      view_height_r <= 15'd768;
      for (int k = 0; k < 8; k++) begin
        cp_r[k] <= '0;
      end
      div_start_r <= 1'b1;
      div_busy_r <= 1'b0;
      div_fin_r <= 1'b0;
      div_cnt_r <= '0;
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP:        step_r <= cfg_data;
          CFG_LINE_LEN:    line_len_r <= cfg_data[6:0];
          CFG_VIEW_WIDTH:  view_width_r <= cfg_data[14:0];
          CFG_VIEW_HEIGHT: view_height_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (load_acc) begin
        cp_r[in_data.point_index].x <= 40'(ld_x >>> 1);
        cp_r[in_data.point_index].y <= 40'(ld_y >>> 1);
      end
      div_start_r <= load_acc || (cfg_valid && cfg_ready);
      div_fin_r <= div_busy_r && div_cnt_r == 6'(DivW - 1);
      if (div_start_r) begin
        div_busy_r <= 1'b1;
        div_cnt_r <= '0;
      end else if (div_busy_r) begin
        if (div_cnt_r == 6'(DivW - 1)) begin
          div_busy_r <= 1'b0;
        end
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      if (cell_acc) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (issue && cnt_r == 3'd5) begin
        busy_r <= 1'b0;
      end else if (issue) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_acc) begin
      row_r <= in_data.cell_row;
      col_r <= in_data.cell_col;
    end
  end

  // lattice index for the strip position
  logic [6:0]  iss_i, iss_j;
  logic [23:0] ti_full, tj_full;
  always_comb begin
    case (cnt_r)
      3'd0, 3'd1: begin
        iss_i = 7'(row_r) + 7'd1;
        iss_j = 7'(col_r);
      end
      3'd2: begin
        iss_i = 7'(row_r) + 7'd1;
        iss_j = 7'(col_r) + 7'd1;
      end
      3'd3: begin
        iss_i = 7'(row_r);
        iss_j = 7'(col_r);
      end
      default: begin
        iss_i = 7'(row_r);
        iss_j = 7'(col_r) + 7'd1;
      end
    endcase
    ti_full = 24'(iss_i) * 24'(step_r);
    tj_full = 24'(iss_j) * 24'(step_r);
  end

  // pipeline registers
  logic [6:0]  s1_i;
  logic        s1_fi, s1_fj, s1_last;
  logic [15:0] s1_ti, s1_tj;

  pt_t                s2_la, s2_lb, s2_ra, s2_rb;
  logic               s2_fi, s2_fj, s2_last;
  logic [15:0]        s2_ti, s2_tj;
  logic signed [55:0] s2_vb_x, s2_vb_y;
  logic [12:0]        s2_ri_x, s2_ri_y;

  pt_t                s3_l, s3_r;
  logic               s3_fj, s3_last;
  logic [15:0]        s3_tj;
  logic signed [55:0] s3_vx, s3_vy;

  pt_t         s4_l, s4_r, s4_ps;
  logic        s4_fj, s4_last;
  logic [15:0] s4_tj;

  pt_t         s5_ea, s5_eb, s5_r;
  logic        s5_fj, s5_last;
  logic [15:0] s5_tj;

  logic signed [50:0] qi_x, qi_y;
  logic [36:0]        fr_x, fr_y;
  logic signed [40:0] msum_x, msum_y;
  pt_t                fin;

  always_comb begin
    qi_x = 51'(q0_x_r) * 51'(signed'({1'b0, s1_i}));
    qi_y = 51'(q0_y_r) * 51'(signed'({1'b0, s1_i}));
    fr_x = 37'(s2_ri_x) * 37'(recip_r);
    fr_y = 37'(s2_ri_y) * 37'(recip_r);
    msum_x = 41'(s3_l.x) + 41'(s3_r.x);
    msum_y = 41'(s3_l.y) + 41'(s3_r.y);
    fin = s5_fj ? s5_r : lerp_pt(s5_ea, s5_eb, s5_tj);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= issue;
      for (int k = 1; k < 6; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_i <= iss_i;
      s1_fi <= |ti_full[23:16];
      s1_fj <= |tj_full[23:16];
      s1_ti <= ti_full[15:0];
      s1_tj <= tj_full[15:0];
      s1_last <= cnt_r == 3'd5;

      s2_la <= lerp_pt(cp_r[0], cp_r[7], s1_ti);
      s2_lb <= lerp_pt(cp_r[7], cp_r[6], s1_ti);
      s2_ra <= lerp_pt(cp_r[2], cp_r[3], s1_ti);
      s2_rb <= lerp_pt(cp_r[3], cp_r[4], s1_ti);
      s2_fi <= s1_fi;
      s2_fj <= s1_fj;
      s2_ti <= s1_ti;
      s2_tj <= s1_tj;
      s2_last <= s1_last;
      s2_vb_x <= 56'(abx) + 56'(qi_x);
      s2_vb_y <= 56'(aby) + 56'(qi_y);
      s2_ri_x <= 13'(r0_x_r) * 13'(s1_i);
      s2_ri_y <= 13'(r0_y_r) * 13'(s1_i);

      s3_l <= s2_fi ? cp_r[6] : lerp_pt(s2_la, s2_lb, s2_ti);
      s3_r <= s2_fi ? cp_r[4] : lerp_pt(s2_ra, s2_rb, s2_ti);
      s3_fj <= s2_fj;
      s3_tj <= s2_tj;
      s3_last <= s2_last;
      s3_vx <= s2_vb_x + 56'(signed'({1'b0, fr_x[36:RecipShift]}));
      s3_vy <= s2_vb_y + 56'(signed'({1'b0, fr_y[36:RecipShift]}));

      s4_l <= s3_l;
      s4_r <= s3_r;
      s4_ps.x <= sat40(56'(signed'(msum_x[40:1])) + s3_vx);
      s4_ps.y <= sat40(56'(signed'(msum_y[40:1])) + s3_vy);
      s4_fj <= s3_fj;
      s4_tj <= s3_tj;
      s4_last <= s3_last;

      s5_ea <= lerp_pt(s4_l, s4_ps, s4_tj);
      s5_eb <= lerp_pt(s4_ps, s4_r, s4_tj);
      s5_r <= s4_r;
      s5_fj <= s4_fj;
      s5_tj <= s4_tj;
      s5_last <= s4_last;

      out_data.vert_x <= fin.x;
      out_data.vert_y <= fin.y;
      out_data.last_vertex <= s5_last;
    end
  end

  assign out_valid = v_r[5];

endmodule
